FILE: src/lz77_pkg.sv
`default_nettype none

package lz77_pkg;

	// Field widths of the request and result words.
	localparam int REQ_TYPE_W = 2;
	localparam int FLAGS_W    = 16;
	localparam int BYTE_W     = 8;
	localparam int MATCH_W    = 16;
	localparam int ERR_W      = 2;
	localparam int SIZE_W     = 32;

	// Match word layout and length coding.
	localparam int DIST_W     = 12;
	localparam int LEN_CODE_W = 4;
	localparam int MAX_MATCH  = 18;
	localparam int COUNT_W    = 5;

	// Number of flags carried by one flag word.
	localparam logic [COUNT_W-1:0] FLAG_COUNT = COUNT_W'(FLAGS_W);

	// The last code is never a valid request.
	typedef enum logic [REQ_TYPE_W-1:0] {
		REQ_FLAGS   = 2'd0,
		REQ_LITERAL = 2'd1,
		REQ_MATCH   = 2'd2,
		REQ_UNUSED  = 2'd3
	} req_type_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_NONE = 2'd0,
		ERR_KIND = 2'd1,
		ERR_DIST = 2'd2,
		ERR_DONE = 2'd3
	} err_code_t;

endpackage

`default_nettype wire

FILE: src/lz77_if.sv
`default_nettype none

// Request channel: flag words, literal bytes and match words.
interface lz77_req_if;
	logic                           valid;
	logic                           ready;
	logic [lz77_pkg::REQ_TYPE_W-1:0] req_type;
	logic [lz77_pkg::FLAGS_W-1:0]    flags_word;
	logic [lz77_pkg::BYTE_W-1:0]     literal_byte;
	logic [lz77_pkg::MATCH_W-1:0]    match_word;

	modport source (output valid, req_type, flags_word, literal_byte, match_word,
		input ready);
	modport sink (input valid, req_type, flags_word, literal_byte, match_word,
		output ready);
endinterface

// Result channel: one decoded byte or one error per word.
interface lz77_res_if;
	logic                       valid;
	logic                       ready;
	logic [lz77_pkg::BYTE_W-1:0] out_byte;
	logic                       last_of_run;
	logic                       done_res;
	logic [lz77_pkg::ERR_W-1:0]  error_code;

	modport source (output valid, out_byte, last_of_run, done_res, error_code,
		input ready);
	modport sink (input valid, out_byte, last_of_run, done_res, error_code,
		output ready);
endinterface

// Configuration channel: the output size register.
interface lz77_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [lz77_pkg::SIZE_W-1:0] raw_size;

	modport source (output valid, raw_size, input ready);
	modport sink (input valid, raw_size, output ready);
endinterface

`default_nettype wire

FILE: src/lz77_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module lz77_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; the data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: src/lz77_token_decompressor.sv
// LZ77 token decompressor.
// Requests arrive on the req channel as flag words, literal bytes and match
// words; decoded bytes leave on the res channel, one byte or one error per
// word. The cfg channel writes the output size, which restarts decoding; it
// is always ready and should only be written while the block is idle.
// A flag word gives no result. A literal or an error gives one result word
// in the next cycle. A match of N bytes (3 to 18, fewer at the end of the
// stream) is copied through the history memory, which has one read port, so
// the copy moves one byte per cycle while the receiver takes them; after the
// match word is taken, each byte is read, then put in the output register.
// Overlapping copies with a distance of one are served by forwarding the
// byte being written to the read that follows it.
// req.ready is high only while no copy runs and the output register is free
// or being emptied, so a stalled receiver holds back both the copy and new
// requests; no word is lost or repeated.
// Reset clears the flag state, the byte count and the output size to zero,
// so every request after reset gives an input-after-done error until the
// size is written. The history memory is not cleared; matches can only reach
// bytes written since the last restart.
`default_nettype none

module lz77_token_decompressor #(
	parameter int WINDOW_SIZE = 4096
) (
	input wire logic     clk,
	input wire logic     arst_n,
	lz77_req_if.sink     req,
	lz77_res_if.source   res,
	lz77_cfg_if.sink     cfg
);

	import lz77_pkg::*;

	localparam int AW = $clog2(WINDOW_SIZE);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_COPY = 2'b10
	} state_t;

	state_t              state_q;
	logic [FLAGS_W-1:0]  flag_shift_q;
	logic [COUNT_W-1:0]  flags_left_q;
	logic [SIZE_W-1:0]   bytes_produced_q;
	logic [SIZE_W-1:0]   remain_q;

	logic [AW-1:0]       src_q;
	logic [COUNT_W-1:0]  iss_left_q;
	logic [COUNT_W-1:0]  out_left_q;
	logic                valid_s1;
	logic                byp_s1;
	logic [BYTE_W-1:0]   byp_data_s1;

	logic                res_valid_q;
	logic [BYTE_W-1:0]   res_byte_q;
	logic                res_last_q;
	logic                res_done_q;
	err_code_t           res_err_q;

	logic                out_free;
	logic                req_fire;
	logic                cfg_fire;
	logic                done_now;
	req_type_t           expect_type;
	logic [DIST_W-1:0]   match_dist;
	logic [COUNT_W-1:0]  len;
	logic [COUNT_W-1:0]  count;
	logic                dist_bad;
	logic                issue;
	logic                move;
	logic [BYTE_W-1:0]   rd_byte;
	logic [BYTE_W-1:0]   ram_rdata;
	logic                ram_we;
	logic [BYTE_W-1:0]   ram_wdata;

	// Handshakes.
	assign out_free  = !res_valid_q || res.ready;
	assign req.ready = (state_q == ST_IDLE) && out_free;
	assign req_fire  = req.valid && req.ready;
	assign cfg.ready = 1'b1;
	assign cfg_fire  = cfg.valid;

	// Decode of the incoming word against the current flag state.
	assign done_now   = (remain_q == '0);
	assign match_dist = req.match_word[MATCH_W-1:LEN_CODE_W];
	assign len        = COUNT_W'(MAX_MATCH) - {1'b0, req.match_word[LEN_CODE_W-1:0]};
	assign dist_bad   = (match_dist == '0) ||
		({{(SIZE_W-DIST_W){1'b0}}, match_dist} > bytes_produced_q);
	assign count      = (remain_q < {{(SIZE_W-COUNT_W){1'b0}}, len}) ?
		remain_q[COUNT_W-1:0] : len;

	always_comb begin
		if (flags_left_q == '0) begin
			expect_type = REQ_FLAGS;
		end else if (flag_shift_q[FLAGS_W-1]) begin
			expect_type = REQ_MATCH;
		end else begin
			expect_type = REQ_LITERAL;
		end
	end

	// Copy pipeline: a read is issued while reads remain and the read stage is empty or being emptied.
	assign move    = (state_q == ST_COPY) && valid_s1 && out_free;
	assign issue   = (state_q == ST_COPY) && (iss_left_q != '0) && (!valid_s1 || out_free);
	assign rd_byte = byp_s1 ? byp_data_s1 : ram_rdata;

	// History write: literals while idle, copied bytes as they move out.
	assign ram_we    = move || (req_fire && !done_now && (req.req_type == expect_type) &&
		(req.req_type == REQ_LITERAL));
	assign ram_wdata = (state_q == ST_COPY) ? rd_byte : req.literal_byte;

	lz77_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (WINDOW_SIZE)
	) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (bytes_produced_q[AW-1:0]),
		.wdata (ram_wdata),
		.re    (issue),
		.raddr (src_q),
		.rdata (ram_rdata)
	);

	// Decoder state and copy control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			flag_shift_q     <= '0;
			flags_left_q     <= '0;
			bytes_produced_q <= '0;
			remain_q         <= '0;
			iss_left_q       <= '0;
			out_left_q       <= '0;
			valid_s1         <= 1'b0;
			byp_s1           <= 1'b0;
		end else if (cfg_fire) begin
			flag_shift_q     <= '0;
			flags_left_q     <= '0;
			bytes_produced_q <= '0;
			remain_q         <= cfg.raw_size;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire && !done_now && (req.req_type == expect_type)) begin
						priority if (req.req_type == REQ_FLAGS) begin
							flag_shift_q <= req.flags_word;
							flags_left_q <= FLAG_COUNT;
						end else if (req.req_type == REQ_LITERAL) begin
							flag_shift_q     <= {flag_shift_q[FLAGS_W-2:0], 1'b0};
							flags_left_q     <= flags_left_q - 1'b1;
							bytes_produced_q <= bytes_produced_q + 1'b1;
							remain_q         <= remain_q - 1'b1;
						end else begin
							if (!dist_bad) begin
								flag_shift_q <= {flag_shift_q[FLAGS_W-2:0], 1'b0};
								flags_left_q <= flags_left_q - 1'b1;
								iss_left_q   <= count;
								out_left_q   <= count;
								state_q      <= ST_COPY;
							end
						end
					end
				end
				ST_COPY: begin
					if (issue) begin
						iss_left_q <= iss_left_q - 1'b1;
						byp_s1     <= move && (bytes_produced_q[AW-1:0] == src_q);
					end
					valid_s1 <= issue || (valid_s1 && !out_free);
					if (move) begin
						bytes_produced_q <= bytes_produced_q + 1'b1;
						remain_q         <= remain_q - 1'b1;
						out_left_q       <= out_left_q - 1'b1;
						if (out_left_q == COUNT_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Copy source address and the forwarded byte.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			src_q <= bytes_produced_q[AW-1:0] - AW'(match_dist);
		end else if (issue) begin
			src_q       <= src_q + 1'b1;
			byp_data_s1 <= rd_byte;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (move || (req_fire && (done_now || (req.req_type != expect_type) ||
			(req.req_type == REQ_LITERAL) || ((req.req_type == REQ_MATCH) && dist_bad)))) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (move) begin
			res_byte_q <= rd_byte;
			res_last_q <= (out_left_q == COUNT_W'(1));
			res_done_q <= (remain_q == SIZE_W'(1));
			res_err_q  <= ERR_NONE;
		end else if (req_fire) begin
			res_byte_q <= '0;
			res_last_q <= 1'b1;
			res_done_q <= 1'b0;
			priority if (done_now) begin
				res_err_q <= ERR_DONE;
			end else if (req.req_type != expect_type) begin
				res_err_q <= ERR_KIND;
			end else if (req.req_type == REQ_LITERAL) begin
				res_byte_q <= req.literal_byte;
				res_done_q <= (remain_q == SIZE_W'(1));
				res_err_q  <= ERR_NONE;
			end else begin
				res_err_q <= ERR_DIST;
			end
		end
	end

	assign res.valid       = res_valid_q;
	assign res.out_byte    = res_byte_q;
	assign res.last_of_run = res_last_q;
	assign res.done_res    = res_done_q;
	assign res.error_code  = res_err_q;

endmodule

`default_nettype wire

FILE: src/lz77_chk.sv
`default_nettype none

// Port-level checks of the decompressor.
module lz77_chk (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      req_valid,
	input wire logic                      req_ready,
	input wire logic [lz77_pkg::REQ_TYPE_W-1:0] req_type,
	input wire logic                      res_valid,
	input wire logic                      res_ready,
	input wire logic [lz77_pkg::ERR_W-1:0] res_error_code
);

	import lz77_pkg::*;

	// A result word stays offered until it is taken.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result word dropped before it was taken");

	// No request is taken while a result word is stuck in the output register.
	a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |-> !req_ready)
		else $error("request taken while the output is stalled");

	// The unused request code always gives an error word in the next cycle.
	a_bad_type_err: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_type == REQ_UNUSED) |=>
		res_valid && (res_error_code != ERR_NONE))
		else $error("unused request code gave no error word");

	// Nothing is offered while reset is applied.
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !res_valid)
		else $error("result offered during reset");

endmodule

bind lz77_token_decompressor lz77_chk u_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.req_type       (req.req_type),
	.res_valid      (res.valid),
	.res_ready      (res.ready),
	.res_error_code (res.error_code)
);

`default_nettype wire

FILE: tb/lz77_decode_checker.sv
// Watches the three channels of the LZ77 decoder, predicts every result word
// from the accepted request words and compares them in order.
module lz77_decode_checker #(
	parameter int WINDOW_SIZE = 4096
) (
	input wire logic clk,
	input wire logic arst_n,
	lz77_req_if      req,
	lz77_res_if      res,
	lz77_cfg_if      cfg,
	output int       outstanding,
	output int       fail_count,
	output int       words_checked
);
	import lz77_pkg::*;

	localparam int AW = $clog2(WINDOW_SIZE);

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
		logic              done;
		err_code_t         code;
	} out_word_t;

	// Result words predicted but not yet seen, oldest first.
	out_word_t pending_words[$];

	// Decoder state as the predictor sees it.
	logic [SIZE_W-1:0]  size_reg;
	logic [SIZE_W-1:0]  produced;
	logic [FLAGS_W-1:0] flag_bits;
	logic [COUNT_W-1:0] flags_avail;
	logic [BYTE_W-1:0]  window [WINDOW_SIZE];
	int                 fails = 0;
	int                 checked = 0;

	function automatic void queue_word(logic [BYTE_W-1:0] data, logic last, logic done,
		err_code_t code);
		pending_words.push_back('{data: data, last: last, done: done, code: code});
	endfunction

	function automatic void check_field(string name, logic [BYTE_W-1:0] want,
		logic [BYTE_W-1:0] got);
		if (got !== want) begin
			fails++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endfunction

	// Works out the result words that one request word causes and updates the state.
	task automatic decode_request(input logic [REQ_TYPE_W-1:0] kind,
		input logic [FLAGS_W-1:0] flags, input logic [BYTE_W-1:0] lit,
		input logic [MATCH_W-1:0] match);
		req_type_t         due_kind;
		logic [DIST_W-1:0] match_dist;
		logic [SIZE_W-1:0] room;
		int                count;
		logic [BYTE_W-1:0] b;
		if (produced == size_reg) begin
			queue_word('0, 1'b1, 1'b0, ERR_DONE);
			return;
		end
		if (flags_avail == 0) begin
			due_kind = REQ_FLAGS;
		end else begin
			due_kind = flag_bits[FLAGS_W-1] ? REQ_MATCH : REQ_LITERAL;
		end
		if (kind != due_kind) begin
			queue_word('0, 1'b1, 1'b0, ERR_KIND);
			return;
		end
		case (due_kind)
			REQ_FLAGS: begin
				flag_bits = flags;
				flags_avail = FLAG_COUNT;
			end
			REQ_LITERAL: begin
				flag_bits = flag_bits << 1;
				flags_avail = flags_avail - 1'b1;
				window[produced[AW-1:0]] = lit;
				produced = produced + 1;
				queue_word(lit, 1'b1, produced == size_reg, ERR_NONE);
			end
			default: begin
				match_dist = match[MATCH_W-1:LEN_CODE_W];
				if (match_dist == 0 || match_dist > produced) begin
					queue_word('0, 1'b1, 1'b0, ERR_DIST);
					return;
				end
				flag_bits = flag_bits << 1;
				flags_avail = flags_avail - 1'b1;
				// The copy stops early when the output size is reached.
				count = MAX_MATCH - match[LEN_CODE_W-1:0];
				room = size_reg - produced;
				if (count > room)
					count = room;
				for (int i = 0; i < count; i++) begin
					b = window[produced[AW-1:0] - AW'(match_dist)];
					window[produced[AW-1:0]] = b;
					produced = produced + 1;
					queue_word(b, i + 1 == count, produced == size_reg, ERR_NONE);
				end
			end
		endcase
	endtask

	// Configuration, then requests, then results, all sampled at the clock edge.
	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		if (!arst_n) begin
			size_reg = '0;
			produced = '0;
			flag_bits = '0;
			flags_avail = '0;
			pending_words.delete();
			outstanding <= 0;
			fail_count <= fails;
			words_checked <= checked;
		end else begin
			if (cfg.valid && cfg.ready) begin
				size_reg = cfg.raw_size;
				produced = '0;
				flag_bits = '0;
				flags_avail = '0;
			end
			if (req.valid && req.ready)
				decode_request(req.req_type, req.flags_word, req.literal_byte,
					req.match_word);
			if (res.valid && res.ready) begin
				checked++;
				if (pending_words.size() == 0) begin
					fails++;
					$display("%0t: unexpected result word, expected none, got byte %0h",
						$time, res.out_byte);
					$display("  last %0b, done %0b, error %0d", res.last_of_run,
						res.done_res, res.error_code);
				end else begin
					want = pending_words.pop_front();
					check_field("byte", want.data, res.out_byte);
					check_field("last_of_run", BYTE_W'(want.last), BYTE_W'(res.last_of_run));
					check_field("done_res", BYTE_W'(want.done), BYTE_W'(res.done_res));
					check_field("error_code", BYTE_W'(want.code), BYTE_W'(res.error_code));
				end
			end
			outstanding <= pending_words.size();
			fail_count <= fails;
			words_checked <= checked;
		end
	end

endmodule

FILE: tb/lz77_token_decompressor_tb.sv
// Drives the LZ77 decoder with hand-built and random token streams and gives
// the verdict; all prediction and comparison sits in the checker beside it.
module lz77_token_decompressor_tb;
	import lz77_pkg::*;

	localparam int WINDOW       = 4096;
	localparam int MAX_GAP      = 14;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 24;
	localparam int STALL_LIMIT  = 2000;
	localparam int RANDOM_WORDS = 110;
	localparam int LONG_SIZE    = 240;

	logic clk = 1'b0;
	logic arst_n;
	logic any_word;
	int   outstanding;
	int   fail_count;
	int   words_checked;
	int   words_sent;
	int   sizes_written;
	bit   tx_gaps;
	bit   rx_gaps;
	bit   hold_rx;

	// Where the decoder should be in the current stream; used only to shape stimulus.
	logic [SIZE_W-1:0]  plan_size;
	logic [SIZE_W-1:0]  plan_made;
	logic [FLAGS_W-1:0] plan_flags;
	int                 plan_left;

	lz77_req_if req_ch ();
	lz77_res_if res_ch ();
	lz77_cfg_if cfg_ch ();

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	lz77_token_decompressor u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	lz77_decode_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req_ch),
		.res           (res_ch),
		.cfg           (cfg_ch),
		.outstanding   (outstanding),
		.fail_count    (fail_count),
		.words_checked (words_checked)
	);

	assign any_word = (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
		(cfg_ch.valid && cfg_ch.ready);

	// Ends the run when no word moves on any channel for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (any_word)
				quiet = 0;
			else
				quiet++;
		end
		$display("Verification failed");
		$finish;
	end

	// Result receiver: random back-pressure in stretches, and one long hold-off.
	initial begin : result_receiver
		int hold;
		res_ch.ready = 1'b0;
		hold = 0;
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready) begin
				if ($urandom_range(0, 15) == 0)
					rx_gaps = !rx_gaps;
				hold = rx_gaps ? $urandom_range(0, MAX_GAP) : 0;
			end
			if (hold_rx) begin
				hold = HOLD_CYCLES;
				hold_rx = 1'b0;
			end
			if (hold > 0) begin
				res_ch.ready <= 1'b0;
				hold--;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Offers one request word after a random gap and waits until it is taken.
	// Fields that the kind does not use carry random values.
	task automatic send_word(input logic [REQ_TYPE_W-1:0] kind, input logic [15:0] value);
		int gap;
		if ($urandom_range(0, 15) == 0)
			tx_gaps = !tx_gaps;
		gap = tx_gaps ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.flags_word <= (kind == REQ_FLAGS) ? value : 16'($urandom);
		req_ch.literal_byte <= (kind == REQ_LITERAL) ? value[7:0] : 8'($urandom);
		req_ch.match_word <= (kind == REQ_MATCH) ? value : 16'($urandom);
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		words_sent++;
	endtask

	// Stops offering and waits until every predicted result word has arrived.
	task automatic wait_results();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// Writes the output size once the block has gone quiet; this restarts decoding.
	task automatic write_size(input logic [SIZE_W-1:0] size_val);
		wait_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_ch.raw_size <= size_val;
		cfg_ch.valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		plan_size = size_val;
		plan_made = '0;
		plan_flags = '0;
		plan_left = 0;
		sizes_written++;
	endtask

	// Sends a word that the decoder must reject: an unused kind, the wrong kind,
	// or a match whose distance is zero or reaches past the bytes produced.
	task automatic send_broken();
		logic [DIST_W-1:0] far;
		case ($urandom_range(0, 2))
			0: send_word(REQ_UNUSED, 16'($urandom));
			1: begin
				if (plan_left == 0)
					send_word($urandom_range(0, 1) ? REQ_LITERAL : REQ_MATCH, 16'($urandom));
				else if (plan_flags[FLAGS_W-1])
					send_word($urandom_range(0, 1) ? REQ_LITERAL : REQ_FLAGS, 16'($urandom));
				else
					send_word($urandom_range(0, 1) ? REQ_MATCH : REQ_FLAGS, 16'($urandom));
			end
			default: begin
				if (plan_left != 0 && plan_flags[FLAGS_W-1]) begin
					if (plan_made >= WINDOW - 1 || $urandom_range(0, 1) == 0)
						far = '0;
					else
						far = DIST_W'($urandom_range(plan_made + 1, WINDOW - 1));
					send_word(REQ_MATCH, {far, 4'($urandom)});
				end else begin
					send_word(REQ_UNUSED, 16'($urandom));
				end
			end
		endcase
	endtask

	// Sends the next word of a well-formed stream, with some noise mixed in.
	// Long mode favours full-length copies and sends no broken words.
	task automatic next_token(input bit long_mode);
		logic [FLAGS_W-1:0] fw;
		logic [DIST_W-1:0]  match_dist;
		logic [3:0]         code;
		logic [SIZE_W-1:0]  reach;
		logic [SIZE_W-1:0]  room;
		int                 len;
		if (plan_made == plan_size) begin
			send_word(2'($urandom_range(0, 3)), 16'($urandom));
			return;
		end
		if (!long_mode && $urandom_range(0, 9) == 0) begin
			send_broken();
			return;
		end
		if (plan_left == 0) begin
			case ($urandom_range(0, 5))
				0: fw = '0;
				1: fw = '1;
				default: fw = 16'($urandom);
			endcase
			if (long_mode)
				fw = '1;
			// Nothing to copy from yet, so the stream must open with a literal.
			if (plan_made == 0)
				fw[FLAGS_W-1] = 1'b0;
			send_word(REQ_FLAGS, fw);
			plan_flags = fw;
			plan_left = FLAGS_W;
		end else if (!plan_flags[FLAGS_W-1]) begin
			send_word(REQ_LITERAL, 16'($urandom));
			plan_made++;
			plan_flags = plan_flags << 1;
			plan_left--;
		end else begin
			reach = (plan_made > WINDOW - 1) ? WINDOW - 1 : plan_made;
			match_dist = DIST_W'(($urandom_range(0, 3) == 0) ? reach :
				$urandom_range(1, reach));
			code = (long_mode && $urandom_range(0, 3) != 0) ? 4'd0 : 4'($urandom);
			send_word(REQ_MATCH, {match_dist, code});
			len = MAX_MATCH - code;
			room = plan_size - plan_made;
			plan_made += (len > room) ? room : len;
			plan_flags = plan_flags << 1;
			plan_left--;
		end
	endtask

	initial begin : stimulus
		int               first_random;
		int               stream_no;
		int               budget;
		logic [SIZE_W-1:0] size_val;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_FLAGS;
		req_ch.flags_word = '0;
		req_ch.literal_byte = '0;
		req_ch.match_word = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.raw_size = '0;
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		hold_rx = 1'b0;
		words_sent = 0;
		sizes_written = 0;
		plan_size = '0;
		plan_made = '0;
		plan_flags = '0;
		plan_left = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The size is zero after reset, so any word counts as input after done.
		send_word(REQ_FLAGS, 16'hFFFF);

		// Hand-built stream of thirty bytes: wrong kinds, bad distances, an
		// overlapping copy of distance one, a full copy and a truncated last copy.
		write_size(32'd30);
		send_word(REQ_MATCH, 16'hFFFF);
		send_word(REQ_UNUSED, 16'h0000);
		send_word(REQ_FLAGS, 16'h3400);
		send_word(REQ_LITERAL, 16'h0000);
		send_word(REQ_MATCH, 16'h0010);
		send_word(REQ_FLAGS, 16'hFFFF);
		send_word(REQ_LITERAL, 16'h00FF);
		send_word(REQ_MATCH, 16'h0000);
		send_word(REQ_MATCH, 16'h003F);
		send_word(REQ_MATCH, 16'h001F);
		send_word(REQ_MATCH, 16'h0050);
		send_word(REQ_LITERAL, 16'h005A);
		send_word(REQ_MATCH, 16'h0020);
		send_word(REQ_LITERAL, 16'h0011);

		// An explicit size of zero, then the largest size.
		write_size('0);
		send_word(REQ_MATCH, 16'h0010);
		write_size('1);
		send_word(REQ_FLAGS, 16'h0000);
		send_word(REQ_LITERAL, 16'h0080);
		send_word(REQ_LITERAL, 16'h007F);

		// Random streams of mixed sizes. The second one starts under a long
		// receiver hold-off; the third pauses half-way until all results are in.
		first_random = words_sent;
		stream_no = 0;
		while (words_sent < first_random + RANDOM_WORDS) begin
			case ($urandom_range(0, 7))
				0, 1: size_val = $urandom_range(1, 8);
				2, 3: size_val = $urandom_range(9, 80);
				4, 5, 6: size_val = $urandom_range(81, 600);
				default: size_val = '1;
			endcase
			write_size(size_val);
			if (stream_no == 1)
				hold_rx = 1'b1;
			budget = $urandom_range(12, 48);
			for (int n = 0; n < budget; n++) begin
				if (stream_no == 2 && n == budget / 2)
					wait_results();
				next_token(1'b0);
				if (plan_made == plan_size && $urandom_range(0, 1) == 0)
					break;
			end
			stream_no++;
		end

		// One stream made mostly of full-length copies.
		write_size(LONG_SIZE);
		while (plan_made != plan_size) next_token(1'b1);

		wait_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d request words under %0d output sizes; %0d result words compared.",
			words_sent, sizes_written, words_checked);
		$display("Streams held literals, overlapping and truncated copies, every error code");
		$display("and a stream built mostly of full-length copies.");
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
